@@ rtl/core/c2s_pkg.sv @@
// Constants and tables for the Cartesian to spherical converter.
// No dependencies; used by cartesian_to_spherical.
`timescale 1ns / 1ps
package c2s_pkg;
    localparam int COORD_WIDTH  = 24;
    localparam int ANGLE_WIDTH  = 24;
    localparam int EXTRA        = 32 - COORD_WIDTH;
    localparam int SQ_IN_W      = 64;
    localparam int SQ_STEPS     = SQ_IN_W / 2;
    localparam int ROOT_W       = SQ_STEPS;
    localparam int REM_W        = ROOT_W + 2;
    localparam int CORDIC_STEPS = 31;
    localparam int CORDIC_GUARD = 24;
    localparam int CW           = 60;
    localparam int ACC_W        = 34;
    localparam int FOLD_W       = 34;

    localparam logic [29:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1
    };

    localparam logic signed [ACC_W-1:0] QUARTER = ACC_W'(64'sd1 <<< 30);
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(64'sd1 <<< (ANGLE_WIDTH - 1));
endpackage

@@ rtl/core/cartesian_to_spherical.sv @@
// Cartesian to spherical conversion: pipelined square roots and two CORDIC units.
// Depends on c2s_pkg.
//
// channel  | handshake        | payload
// command  | start, busy      | i_coord_x, i_coord_y, i_coord_z
// result   | o_valid (strobe) | o_radius, o_polar_angle, o_azimuth
//
// One point enters every cycle; busy is always low.
// Each result passes through four input and square stages, 32 root digit
// stages, rounding and fold stages, 31 CORDIC stages and the output register.
// Depth is set by the root digit count and CORDIC steps.
// Synchronous reset clears all valid bits; the receiver cannot stall.
`timescale 1ns / 1ps
module cartesian_to_spherical (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_coord_z,
    output logic                                   o_valid,
    output logic        [c2s_pkg::COORD_WIDTH-1:0] o_radius,
    output logic        [c2s_pkg::ANGLE_WIDTH-1:0] o_polar_angle,
    output logic signed [c2s_pkg::ANGLE_WIDTH-1:0] o_azimuth
);
    localparam int W  = c2s_pkg::COORD_WIDTH;
    localparam int SQ = c2s_pkg::SQ_STEPS;
    localparam int CS = c2s_pkg::CORDIC_STEPS;
    localparam int CW = c2s_pkg::CW;
    localparam int AW = c2s_pkg::ACC_W;
    localparam int RW = c2s_pkg::ROOT_W;
    localparam int MW = c2s_pkg::REM_W;
    localparam int FW = c2s_pkg::FOLD_W;

    assign busy = 1'b0;

    // front stages
    logic                r_v_in, r_v_abs, r_v_sq;
    logic signed [W-1:0] r_x_in, r_y_in, r_z_in;
    logic signed [W-1:0] r_x_abs, r_y_abs, r_z_abs;
    logic signed [W-1:0] r_x_sq, r_y_sq, r_z_sq;
    logic        [W-1:0] r_ax, r_ay, r_az;
    logic      [2*W-1:0] r_sx, r_sy, r_sz;

    // root digit stages
    logic                r_sv  [0:SQ];
    logic signed [W-1:0] r_sqx [0:SQ];
    logic signed [W-1:0] r_sqy [0:SQ];
    logic signed [W-1:0] r_sqz [0:SQ];
    logic [c2s_pkg::SQ_IN_W-1:0] r_pn [0:SQ];
    logic [c2s_pkg::SQ_IN_W-1:0] r_tn [0:SQ];
    logic [RW-1:0] r_proot [0:SQ];
    logic [RW-1:0] r_troot [0:SQ];
    logic [MW-1:0] r_prem  [0:SQ];
    logic [MW-1:0] r_trem  [0:SQ];

    // round stage
    logic                r_v_rnd;
    logic signed [W-1:0] r_x_rnd, r_y_rnd, r_z_rnd;
    logic        [W-1:0] r_rad_rnd;
    logic       [RW-1:0] r_rho;

    // CORDIC stages: p = polar, a = azimuth
    logic                 r_cv    [0:CS];
    logic        [W-1:0]  r_crad  [0:CS];
    logic                 r_pzero [0:CS];
    logic                 r_azero [0:CS];
    logic signed [CW-1:0] r_pa    [0:CS];
    logic signed [CW-1:0] r_pb    [0:CS];
    logic signed [CW-1:0] r_aa    [0:CS];
    logic signed [CW-1:0] r_ab    [0:CS];
    logic signed [AW-1:0] r_pacc  [0:CS];
    logic signed [AW-1:0] r_aacc  [0:CS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in  <= 1'b0;
            r_v_abs <= 1'b0;
            r_v_sq  <= 1'b0;
            r_sv[0] <= 1'b0;
            r_v_rnd <= 1'b0;
            r_cv[0] <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v_in  <= start && !busy;
            r_v_abs <= r_v_in;
            r_v_sq  <= r_v_abs;
            r_sv[0] <= r_v_sq;
            r_v_rnd <= r_sv[SQ];
            r_cv[0] <= r_v_rnd;
            o_valid <= r_cv[CS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_in  <= i_coord_x;
        r_y_in  <= i_coord_y;
        r_z_in  <= i_coord_z;
        r_x_abs <= r_x_in;
        r_y_abs <= r_y_in;
        r_z_abs <= r_z_in;
        r_ax    <= r_x_in[W-1] ? W'(-r_x_in) : W'(r_x_in);
        r_ay    <= r_y_in[W-1] ? W'(-r_y_in) : W'(r_y_in);
        r_az    <= r_z_in[W-1] ? W'(-r_z_in) : W'(r_z_in);
        r_x_sq  <= r_x_abs;
        r_y_sq  <= r_y_abs;
        r_z_sq  <= r_z_abs;
        r_sx    <= r_ax * r_ax;
        r_sy    <= r_ay * r_ay;
        r_sz    <= r_az * r_az;
        r_sqx[0]   <= r_x_sq;
        r_sqy[0]   <= r_y_sq;
        r_sqz[0]   <= r_z_sq;
        r_pn[0]    <= (64'(r_sx) + 64'(r_sy)) << (2 * c2s_pkg::EXTRA);
        r_tn[0]    <= 64'(r_sx) + 64'(r_sy) + 64'(r_sz);
        r_proot[0] <= '0;
        r_troot[0] <= '0;
        r_prem[0]  <= '0;
        r_trem[0]  <= '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < SQ; gi++) begin : g_root
            logic [MW+1:0] psh, tsh, ptr, ttr;
            logic          pge, tge;
            always_comb begin
                psh = {r_prem[gi], r_pn[gi][63:62]};
                tsh = {r_trem[gi], r_tn[gi][63:62]};
                ptr = {2'b00, r_proot[gi], 2'b01};
                ttr = {2'b00, r_troot[gi], 2'b01};
                pge = psh >= ptr;
                tge = tsh >= ttr;
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sv[gi+1] <= 1'b0;
                end else begin
                    r_sv[gi+1] <= r_sv[gi];
                end
                r_sqx[gi+1]   <= r_sqx[gi];
                r_sqy[gi+1]   <= r_sqy[gi];
                r_sqz[gi+1]   <= r_sqz[gi];
                r_pn[gi+1]    <= {r_pn[gi][61:0], 2'b00};
                r_tn[gi+1]    <= {r_tn[gi][61:0], 2'b00};
                r_proot[gi+1] <= {r_proot[gi][RW-2:0], pge};
                r_troot[gi+1] <= {r_troot[gi][RW-2:0], tge};
                r_prem[gi+1]  <= pge ? MW'(psh - ptr) : MW'(psh);
                r_trem[gi+1]  <= tge ? MW'(tsh - ttr) : MW'(tsh);
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_x_rnd   <= r_sqx[SQ];
        r_y_rnd   <= r_sqy[SQ];
        r_z_rnd   <= r_sqz[SQ];
        r_rad_rnd <= W'(r_troot[SQ] + RW'(r_trem[SQ] > {2'b00, r_troot[SQ]}));
        r_rho     <= r_proot[SQ] + RW'(r_prem[SQ] > {2'b00, r_proot[SQ]});
    end

    // quadrant fold into the right half plane
    logic signed [FW-1:0] n_pa, n_pb, n_aa, n_ab;
    logic signed [AW-1:0] n_pacc, n_aacc;
    always_comb begin
        n_pa   = FW'(r_z_rnd) <<< c2s_pkg::EXTRA;
        n_pb   = $signed({2'b00, r_rho});
        n_aa   = FW'(r_x_rnd);
        n_ab   = FW'(r_y_rnd);
        n_pacc = '0;
        n_aacc = '0;
        if (n_pa < 0) begin
            n_pacc = c2s_pkg::QUARTER;
            {n_pa, n_pb} = {n_pb, -n_pa};
        end
        if (n_aa < 0) begin
            if (n_ab >= 0) begin
                n_aacc = c2s_pkg::QUARTER;
                {n_aa, n_ab} = {n_ab, -n_aa};
            end else begin
                n_aacc = -c2s_pkg::QUARTER;
                {n_aa, n_ab} = {-n_ab, n_aa};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_crad[0]  <= r_rad_rnd;
        r_pzero[0] <= (r_z_rnd == '0) && (r_rho == '0);
        r_azero[0] <= (r_x_rnd == '0) && (r_y_rnd == '0);
        r_pa[0]    <= CW'(n_pa) <<< c2s_pkg::CORDIC_GUARD;
        r_pb[0]    <= CW'(n_pb) <<< c2s_pkg::CORDIC_GUARD;
        r_aa[0]    <= CW'(n_aa) <<< c2s_pkg::CORDIC_GUARD;
        r_ab[0]    <= CW'(n_ab) <<< c2s_pkg::CORDIC_GUARD;
        r_pacc[0]  <= n_pacc;
        r_aacc[0]  <= n_aacc;
    end

    generate
        for (gi = 0; gi < CS; gi++) begin : g_cordic
            logic signed [CW-1:0] pda, pdb, ada, adb;
            logic signed [AW-1:0] tab;
            always_comb begin
                pda = r_pb[gi] >>> gi;
                pdb = r_pa[gi] >>> gi;
                ada = r_ab[gi] >>> gi;
                adb = r_aa[gi] >>> gi;
                tab = $signed({4'b0000, c2s_pkg::ATAN_TAB[gi]});
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cv[gi+1] <= 1'b0;
                end else begin
                    r_cv[gi+1] <= r_cv[gi];
                end
                r_crad[gi+1]  <= r_crad[gi];
                r_pzero[gi+1] <= r_pzero[gi];
                r_azero[gi+1] <= r_azero[gi];
                if (!r_pb[gi][CW-1]) begin
                    r_pa[gi+1]   <= r_pa[gi] + pda;
                    r_pb[gi+1]   <= r_pb[gi] - pdb;
                    r_pacc[gi+1] <= r_pacc[gi] + tab;
                end else begin
                    r_pa[gi+1]   <= r_pa[gi] - pda;
                    r_pb[gi+1]   <= r_pb[gi] + pdb;
                    r_pacc[gi+1] <= r_pacc[gi] - tab;
                end
                if (!r_ab[gi][CW-1]) begin
                    r_aa[gi+1]   <= r_aa[gi] + ada;
                    r_ab[gi+1]   <= r_ab[gi] - adb;
                    r_aacc[gi+1] <= r_aacc[gi] + tab;
                end else begin
                    r_aa[gi+1]   <= r_aa[gi] - ada;
                    r_ab[gi+1]   <= r_ab[gi] + adb;
                    r_aacc[gi+1] <= r_aacc[gi] - tab;
                end
            end
        end
    endgenerate

    logic signed [AW-1:0] n_pfin, n_afin;
    always_comb begin
        n_pfin = (r_pacc[CS] + AW'(128)) >>> 8;
        n_afin = (r_aacc[CS] + AW'(128)) >>> 8;
    end

    always_ff @(posedge i_clk) begin
        o_radius <= r_crad[CS];
        if (r_pzero[CS] || n_pfin < 0) begin
            o_polar_angle <= '0;
        end else if (n_pfin > c2s_pkg::HALF) begin
            o_polar_angle <= c2s_pkg::ANGLE_WIDTH'(c2s_pkg::HALF);
        end else begin
            o_polar_angle <= n_pfin[c2s_pkg::ANGLE_WIDTH-1:0];
        end
        o_azimuth <= r_azero[CS] ? '0 : n_afin[c2s_pkg::ANGLE_WIDTH-1:0];
    end

`ifndef SYNTH
    a_polar_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_polar_angle <= c2s_pkg::ANGLE_WIDTH'(c2s_pkg::HALF)))
        else $error("polar angle above pi");
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_radius == '0) |-> (o_polar_angle == '0 && o_azimuth == '0))
        else $error("origin gives nonzero angle");
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");
`endif
endmodule

@@ tb/c2s_checker.sv @@
// Checker for cartesian_to_spherical: watches the command and result channels,
// predicts each result and compares field by field. Depends on c2s_pkg.
`timescale 1ns / 1ps
module c2s_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic                                   i_busy,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_coord_z,
    input  logic                                   i_valid,
    input  logic        [c2s_pkg::COORD_WIDTH-1:0] i_radius,
    input  logic        [c2s_pkg::ANGLE_WIDTH-1:0] i_polar_angle,
    input  logic signed [c2s_pkg::ANGLE_WIDTH-1:0] i_azimuth,
    output int                                     o_errors,
    output int                                     o_pending
);
    localparam int CW = c2s_pkg::COORD_WIDTH;
    localparam int AW = c2s_pkg::ANGLE_WIDTH;

    typedef struct packed {
        logic        [CW-1:0] radius;
        logic        [AW-1:0] polar;
        logic signed [AW-1:0] azimuth;
    } t_sph;

    localparam longint ARCTAN [0:30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1
    };

    t_sph spherical_q[$];

    function automatic longint unsigned round_root(longint unsigned n);
        longint unsigned res, bit_w, rem;
        res = 0;
        bit_w = 64'd1 << 62;
        rem = n;
        while (bit_w > rem) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (rem >= res + bit_w) begin
                rem = rem - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        if (rem > res) res = res + 1;
        return res;
    endfunction

    // atan2(b, a), 2^24 units per turn
    function automatic longint vector_angle(longint b, longint a);
        longint acc, t, da, db;
        acc = 0;
        if (a == 0 && b == 0) return 0;
        if (a < 0) begin
            if (b >= 0) begin
                t = a; a = b; b = -t; acc = 64'sd1 <<< 30;
            end else begin
                t = a; a = -b; b = t; acc = -(64'sd1 <<< 30);
            end
        end
        a = a <<< 24;
        b = b <<< 24;
        for (int i = 0; i < 31; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
                a += da; b -= db; acc += ARCTAN[i];
            end else begin
                a -= da; b += db; acc -= ARCTAN[i];
            end
        end
        return (acc + 128) >>> 8;
    endfunction

    function automatic t_sph to_spherical(longint x, longint y, longint z);
        longint unsigned ax, ay, az, plane;
        longint rho, polar;
        t_sph r;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        plane = ax * ax + ay * ay;
        r.radius = CW'(round_root(plane + az * az));
        rho = longint'(round_root(plane << (2 * (32 - CW))));
        polar = vector_angle(rho, z * (64'sd1 <<< (32 - CW)));
        if (polar < 0) polar = 0;
        if (polar > (64'sd1 <<< (AW - 1))) polar = 64'sd1 <<< (AW - 1);
        r.polar = AW'(polar);
        r.azimuth = AW'(vector_angle(y, x));
        return r;
    endfunction

    assign o_pending = spherical_q.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_sph exp_r;
        if (i_rst_n && i_start && !i_busy)
            spherical_q.push_back(to_spherical(i_coord_x, i_coord_y, i_coord_z));
        if (i_rst_n && i_valid) begin
            if (spherical_q.size() == 0) begin
                $display("%0t: unexpected result r=%0d polar=%0d az=%0d", $time,
                         i_radius, i_polar_angle, i_azimuth);
                o_errors <= o_errors + 1;
            end else begin
                exp_r = spherical_q.pop_front();
                if (exp_r.radius !== i_radius || exp_r.polar !== i_polar_angle ||
                    exp_r.azimuth !== i_azimuth) begin
                    $display({"%0t: mismatch expected r=%0d polar=%0d az=%0d,",
                              " got r=%0d polar=%0d az=%0d"},
                             $time, exp_r.radius, exp_r.polar, exp_r.azimuth,
                             i_radius, i_polar_angle, i_azimuth);
                    o_errors <= o_errors + 1;
                end
            end
        end
    end
endmodule

@@ tb/cartesian_to_spherical_tb.sv @@
// Testbench top for cartesian_to_spherical: directed and random points under
// several sender idling phases. Depends on c2s_pkg and c2s_checker.
`timescale 1ns / 1ps
module cartesian_to_spherical_tb;
    localparam int CW = c2s_pkg::COORD_WIDTH;
    localparam int AW = c2s_pkg::ANGLE_WIDTH;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 start = 0;
    logic                 busy;
    logic signed [CW-1:0] i_coord_x = '0;
    logic signed [CW-1:0] i_coord_y = '0;
    logic signed [CW-1:0] i_coord_z = '0;
    logic                 o_valid;
    logic        [CW-1:0] o_radius;
    logic        [AW-1:0] o_polar_angle;
    logic signed [AW-1:0] o_azimuth;
    int                   errors;
    int                   pending;
    int                   idle_pct;

    always #1 i_clk = ~i_clk;

    cartesian_to_spherical u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .o_valid(o_valid), .o_radius(o_radius), .o_polar_angle(o_polar_angle),
        .o_azimuth(o_azimuth)
    );

    c2s_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_valid(o_valid), .i_radius(o_radius), .i_polar_angle(o_polar_angle),
        .i_azimuth(o_azimuth), .o_errors(errors), .o_pending(pending)
    );

    task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                              logic signed [CW-1:0] z);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(511)) - 256);
            2: return $urandom_range(1) ? CMAX : CMIN;
            3: return '0;
            default: return CW'($urandom) >>> $urandom_range(CW - 1);
        endcase
    endfunction

    initial begin
        idle_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_point(0, 0, 0);
        send_point(0, 0, 1);
        send_point(0, 0, -1);
        send_point(0, 0, CMAX);
        send_point(0, 0, CMIN);
        send_point(CMAX, CMAX, CMAX);
        send_point(CMIN, CMIN, CMIN);
        send_point(CMIN, CMAX, CMIN);
        send_point(CMAX, CMIN, CMAX);
        send_point(-1, 0, 0);
        send_point(CMIN, 0, 5);
        send_point(1, 0, 0);
        send_point(0, 1, 0);
        send_point(0, -1, 0);
        send_point(-1, -1, 0);
        send_point(-1, 1, 0);
        send_point(1, -1, -1);
        send_point(65536, 65536, 65536);
        send_point(CMAX, 0, 0);
        send_point(0, CMIN, 0);

        // wait for the pipeline to drain before the random part
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 80 : (ph == 3) ? 22 : 0;
            repeat (145) send_point(rand_coord(), rand_coord(), rand_coord());
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (errors == 0)
            $display("PASS cartesian_to_spherical");
        else
            $display("FAIL cartesian_to_spherical");
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL cartesian_to_spherical");
        $finish;
    end
endmodule
